/* rtl/skvt_pkg.sv */
// Shared types and constants for the sorted key/name table unit.
// No dependencies; compile first.
package skvt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BITS_DEF = 16;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_DECIDE,
    S_SHIFT,
    S_INSERT,
    S_FINISH
  } state_t;

endpackage

/* rtl/skvt_if.sv */
// Request and response channel interfaces of the sorted key/name table unit.
// Depends on skvt_pkg.
interface skvt_req_if;
  import skvt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [NAME_W-1:0]   name_in;

  modport source (output valid, action, key, name_in, input ready);
  modport sink   (input valid, action, key, name_in, output ready);
endinterface

interface skvt_rsp_if;
  import skvt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NAME_W-1:0]   name_out;

  modport source (output valid, status, name_out, input ready);
  modport sink   (input valid, status, name_out, output ready);
endinterface

/* rtl/skvt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sorted_key_value_table_unit.sv */
// Sorted key/name table: insert, find and delete on up to CAPACITY entries in key order.
// One transaction at a time: a new request is taken only in idle, after the last response
// has been issued. The binary search loop and the entry-by-entry shift on insert and delete,
// both through the one RAM read port, set the pace. Reset (synchronous, rst_n low) empties
// the table at once; no clearing pass is needed. Depends on skvt_pkg, skvt_if, skvt_ram.
module sorted_key_value_table_unit #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = skvt_pkg::KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  skvt_req_if.sink   in_req,
  skvt_rsp_if.source out_rsp
);
  import skvt_pkg::*;

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned EW  = KEY_BITS + NAME_W;
  localparam int unsigned KXW = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic [AW-1:0]       end_r, end_nxt;
  logic                rd_go_r, rd_go_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic                up_r, up_nxt;
  status_t             stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [ACTION_W-1:0] action_r, action_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;
  logic [NAME_W-1:0]   hit_name_r, hit_name_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [NAME_W-1:0]   out_name_r, out_name_nxt;

  logic [KXW-1:0]      key_wide;
  logic [CW:0]         mid_sum;
  logic [AW-1:0]       mid;
  logic [CW:0]         del_next;
  logic [KEY_BITS-1:0] rd_key;
  logic [NAME_W-1:0]   rd_name;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  skvt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_wide = KXW'(in_req.key);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = AW'(mid_sum >> 1);
  assign del_next = {1'b0, lo_r} + 1'b1;
  assign rd_key   = ram_rdata[EW-1:NAME_W];
  assign rd_name  = ram_rdata[NAME_W-1:0];

  // next state and register updates
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    found_nxt      = found_r;
    rp_nxt         = rp_r;
    wa_nxt         = wa_r;
    end_nxt        = end_r;
    rd_go_nxt      = rd_go_r;
    wr_pend_nxt    = wr_pend_r;
    up_nxt         = up_r;
    stat_nxt       = stat_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    name_nxt       = name_r;
    hit_name_nxt   = hit_name_r;
    out_status_nxt = out_status_r;
    out_name_nxt   = out_name_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          action_nxt = in_req.action;
          key_nxt    = key_wide[KEY_BITS-1:0];
          name_nxt   = in_req.name_in;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          found_nxt  = 1'b0;
          state_nxt  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        state_nxt = (lo_r < hi_r) ? S_COMPARE : S_DECIDE;
      end
      S_COMPARE: begin
        if (rd_key < key_r) begin
          lo_nxt = CW'(mid) + 1'b1;
        end else begin
          hi_nxt = CW'(mid);
          if (rd_key == key_r) begin
            found_nxt    = 1'b1;
            hit_name_nxt = rd_name;
          end
        end
        state_nxt = S_SEARCH;
      end
      S_DECIDE: begin
        stat_nxt  = ST_MISS;
        state_nxt = S_FINISH;
        case (action_r)
          ACT_INSERT: begin
            if (found_r) begin
              stat_nxt = ST_MISS;
            end else if (count_r >= CW'(CAPACITY)) begin
              stat_nxt = ST_FULL;
            end else begin
              up_nxt      = 1'b1;
              rp_nxt      = AW'(count_r - 1'b1);
              end_nxt     = AW'(lo_r);
              rd_go_nxt   = count_r > lo_r;
              wr_pend_nxt = 1'b0;
              state_nxt   = S_SHIFT;
            end
          end
          ACT_FIND: begin
            if (found_r) begin
              stat_nxt = ST_OK;
            end
          end
          ACT_DELETE: begin
            if (found_r) begin
              up_nxt      = 1'b0;
              rp_nxt      = AW'(del_next);
              end_nxt     = AW'(count_r - 1'b1);
              rd_go_nxt   = del_next < {1'b0, count_r};
              wr_pend_nxt = 1'b0;
              state_nxt   = S_SHIFT;
            end
          end
          default: begin
            stat_nxt = ST_MISS;
          end
        endcase
      end
      S_SHIFT: begin
        rd_go_nxt   = rd_go_r && (rp_r != end_r);
        wr_pend_nxt = rd_go_r;
        wa_nxt      = up_r ? rp_r + 1'b1 : rp_r - 1'b1;
        if (rd_go_r) begin
          rp_nxt = up_r ? rp_r - 1'b1 : rp_r + 1'b1;
        end
        if (!rd_go_r && !wr_pend_r) begin
          if (up_r) begin
            state_nxt = S_INSERT;
          end else begin
            count_nxt = count_r - 1'b1;
            stat_nxt  = ST_OK;
            state_nxt = S_FINISH;
          end
        end
      end
      S_INSERT: begin
        count_nxt = count_r + 1'b1;
        stat_nxt  = ST_OK;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_name_nxt   = (action_r == ACT_FIND && found_r) ? hit_name_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // RAM port and handshake drive
  always_comb begin
    in_req.ready = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wa_r;
    ram_wdata    = ram_rdata;
    ram_raddr    = rp_r;

    unique case (state_r)
      S_IDLE: begin
        in_req.ready = rst_n;
      end
      S_SEARCH: begin
        ram_raddr = mid;
      end
      S_SHIFT: begin
        ram_we = wr_pend_r;
      end
      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(lo_r);
        ram_wdata = {key_r, name_r};
      end
      S_COMPARE, S_DECIDE, S_FINISH: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      found_r     <= 1'b0;
      rp_r        <= '0;
      wa_r        <= '0;
      end_r       <= '0;
      rd_go_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      up_r        <= 1'b0;
      stat_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      found_r     <= found_nxt;
      rp_r        <= rp_nxt;
      wa_r        <= wa_nxt;
      end_r       <= end_nxt;
      rd_go_r     <= rd_go_nxt;
      wr_pend_r   <= wr_pend_nxt;
      up_r        <= up_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    name_r       <= name_nxt;
    hit_name_r   <= hit_name_nxt;
    out_status_r <= out_status_nxt;
    out_name_r   <= out_name_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.name_out = out_name_r;

endmodule

/* test/skvt_checker.sv */
`timescale 1ns / 100ps
// Checker for the sorted key/name table unit: tracks its own copy of the table,
// predicts each response and compares it with what the unit returns.
// Depends on skvt_pkg and skvt_if.
module skvt_checker
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  skvt_req_if        req,
  skvt_rsp_if        rsp,
  output int         fail_count,
  output int         pending
);

  localparam logic [31:0] KEY_MASK32 =
    (KEY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << KEY_BITS) - 32'd1);

  typedef struct packed {
    status_t           status;
    logic [NAME_W-1:0] name;
  } table_reply_t;

  logic [KEY_W-1:0]  keys_held  [CAPACITY];
  logic [NAME_W-1:0] names_held [CAPACITY];
  int                held_count;
  table_reply_t      replies_due [$];

  assign pending = replies_due.size();

  function automatic table_reply_t apply_request(input logic [ACTION_W-1:0] act,
                                                 input logic [KEY_W-1:0]    key_raw,
                                                 input logic [NAME_W-1:0]   nm);
    table_reply_t     res;
    logic [KEY_W-1:0] k;
    int               pos;
    bit               hit;
    k          = key_raw & KEY_MASK32[KEY_W-1:0];
    res.status = ST_MISS;
    res.name   = '0;
    pos        = 0;
    while (pos < held_count && keys_held[pos] < k) pos++;
    hit = (pos < held_count) && (keys_held[pos] == k);
    case (act)
      ACT_INSERT: begin
        if (hit) begin
          res.status = ST_MISS;
        end else if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = held_count; i > pos; i--) begin
            keys_held[i]  = keys_held[i-1];
            names_held[i] = names_held[i-1];
          end
          keys_held[pos]  = k;
          names_held[pos] = nm;
          held_count++;
          res.status = ST_OK;
        end
      end
      ACT_FIND: begin
        if (hit) begin
          res.status = ST_OK;
          res.name   = names_held[pos];
        end
      end
      ACT_DELETE: begin
        if (hit) begin
          for (int i = pos; i + 1 < held_count; i++) begin
            keys_held[i]  = keys_held[i+1];
            names_held[i] = names_held[i+1];
          end
          held_count--;
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    table_reply_t due;
    if (!rst_n) begin
      held_count <= 0;
    end else begin
      if (req.valid && req.ready) begin
        replies_due.push_back(apply_request(req.action, req.key, req.name_in));
      end
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected response: status %0d, name_out %h", rsp.status, rsp.name_out);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          if (rsp.status !== due.status) begin
            $error("status mismatch: expected %0d, got %0d", due.status, rsp.status);
            fail_count++;
          end
          if (rsp.name_out !== due.name) begin
            $error("name_out mismatch: expected %h, got %h", due.name, rsp.name_out);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the sorted key/name table unit: drives requests, paces responses
// and gives the verdict. Depends on skvt_pkg, skvt_if, skvt_checker and the unit.
module tb;
  import skvt_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned         RANDOM_ITEMS = 1850;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_count;
  int   rsp_taken;

  skvt_req_if req_ch ();
  skvt_rsp_if rsp_ch ();

  sorted_key_value_table_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  skvt_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k,
                              input logic [NAME_W-1:0] nm);
    int gap;
    gap = ((sent_count / 200) % 5 == 4) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.key     <= k;
    req_ch.name_in <= nm;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sent_count++;
  endtask

  function automatic logic [NAME_W-1:0] draw_name();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  task automatic run_phase(input int length, input int pool, input int base,
                           input int ins_pct, input int find_pct);
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    k;
    int                  roll;
    repeat (length) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) act = ACT_UNUSED;
      else if (roll < 4 + ins_pct) act = ACT_INSERT;
      else if (roll < 4 + ins_pct + find_pct) act = ACT_FIND;
      else act = ACT_DELETE;
      if ($urandom_range(0, 19) == 0) k = KEY_W'($urandom());
      else k = KEY_W'(base + $urandom_range(0, pool - 1));
      send_request(act, k, draw_name());
    end
  endtask

  // response side: random back-pressure, calm stretches, two long hold-offs
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    rsp_taken    = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ((rsp_taken / 150) % 4 == 3) ? 0 : $urandom_range(0, 6);
      if (rsp_taken == 60 || rsp_taken == 900) gap = 400;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      rsp_taken++;
    end
  end

  initial begin
    int pool;
    int base;
    int episode;
    rst_n          = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_INSERT;
    req_ch.key     = '0;
    req_ch.name_in = '0;
    sent_count     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_request(ACT_FIND,   16'h1234, 64'h0);
    send_request(ACT_DELETE, 16'h1234, 64'h0);
    send_request(ACT_UNUSED, 16'h1234, 64'h1);
    send_request(ACT_INSERT, 16'h8000, 64'hDEAD_BEEF_0123_4567);
    send_request(ACT_INSERT, 16'h0000, 64'h0);
    send_request(ACT_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_INSERT, 16'h8000, 64'h1111_2222_3333_4444);
    send_request(ACT_FIND,   16'h0000, 64'h0);
    send_request(ACT_FIND,   16'hFFFF, 64'h0);
    send_request(ACT_FIND,   16'h7FFF, 64'h0);
    send_request(ACT_INSERT, 16'h7FFF, 64'h5555_5555_5555_5555);
    send_request(ACT_INSERT, 16'h8001, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ACT_FIND,   16'h8000, 64'h0);
    send_request(ACT_UNUSED, 16'h8000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_DELETE, 16'h0000, 64'h0);
    send_request(ACT_DELETE, 16'hFFFF, 64'h0);
    send_request(ACT_DELETE, 16'hFFFF, 64'h0);
    send_request(ACT_DELETE, 16'h8000, 64'h0);
    send_request(ACT_FIND,   16'h8001, 64'h0);
    send_request(ACT_DELETE, 16'h7FFF, 64'h0);
    send_request(ACT_DELETE, 16'h8001, 64'h0);
    send_request(ACT_FIND,   16'h8001, 64'h0);
    send_request(ACT_INSERT, 16'hFFFF, {$urandom(), $urandom()});

    // episodes: fill (past capacity with the larger key pools), mix, then drain, mostly over one key window
    episode = 0;
    while (sent_count + 170 < RANDOM_ITEMS) begin
      case ((episode == 0) ? 2 : $urandom_range(0, 3))
        0:       pool = 16;
        1:       pool = 48;
        2:       pool = 200;
        default: pool = 400;
      endcase
      case ($urandom_range(0, 3))
        0:       base = 0;
        1:       base = 65536 - pool;
        default: base = $urandom_range(0, 65536 - pool);
      endcase
      run_phase(140, pool, base, 80, 10);
      run_phase(60,  pool, base, 30, 40);
      run_phase(140, pool, base, 10, 20);
      episode++;
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/skvt_pkg.sv
rtl/skvt_if.sv
rtl/skvt_ram.sv
rtl/sorted_key_value_table_unit.sv
test/skvt_checker.sv
test/tb.sv
